FILE: rtl/core/cccu_pkg.sv
// Shared definitions for the cylindrical / Cartesian CORDIC converter.
// Holds the default sizes, the gain constant, the arctangent table and the stage control word.
// No dependencies; every other file of the block imports this package.
package cccu_pkg;

	localparam int COORD_WIDTH_DEF   = 16;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// Fraction bits the coordinates carry inside the CORDIC rows.
	localparam int FRAC_BITS = 16;
	// Converged CORDIC gain, 0.6072529350..., as a 32-bit unsigned fraction.
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
	// Highest number of rotation rows the arctangent table supports.
	localparam int MAX_STAGES = 32;

	// Control word that travels beside the data of every pipeline stage.
	typedef struct packed {
		logic vld;     // Stage holds a live beat.
		logic kind;    // Zero for rotation (to Cartesian), one for vectoring.
		logic origin;  // Vectoring beat whose x and y were both zero.
	} ctl_t;

	// atan(2^-i) as a fraction of a full turn in 32 bits, rounded to nearest.
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] t;
		case (idx)
			5'd0:    t = 32'd536870912;
			5'd1:    t = 32'd316933406;
			5'd2:    t = 32'd167458907;
			5'd3:    t = 32'd85004756;
			5'd4:    t = 32'd42667331;
			5'd5:    t = 32'd21354465;
			5'd6:    t = 32'd10679838;
			5'd7:    t = 32'd5340245;
			5'd8:    t = 32'd2670163;
			5'd9:    t = 32'd1335087;
			5'd10:   t = 32'd667544;
			5'd11:   t = 32'd333772;
			5'd12:   t = 32'd166886;
			5'd13:   t = 32'd83443;
			5'd14:   t = 32'd41722;
			5'd15:   t = 32'd20861;
			5'd16:   t = 32'd10430;
			5'd17:   t = 32'd5215;
			5'd18:   t = 32'd2608;
			5'd19:   t = 32'd1304;
			5'd20:   t = 32'd652;
			5'd21:   t = 32'd326;
			5'd22:   t = 32'd163;
			5'd23:   t = 32'd81;
			5'd24:   t = 32'd41;
			5'd25:   t = 32'd20;
			5'd26:   t = 32'd10;
			5'd27:   t = 32'd5;
			5'd28:   t = 32'd3;
			5'd29:   t = 32'd1;
			5'd30:   t = 32'd1;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/core/cccu_stage.sv
// One registered CORDIC row: a shift-and-add micro-rotation on x, y and the angle.
// Depends on cccu_pkg for the control word and the arctangent table.
// Rotation beats steer by the sign of the residual angle, vectoring beats by the sign of y.
module cccu_stage #(
	parameter int DW  = 35,
	parameter int HW  = 16,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cccu_pkg::ctl_t       ctl,
	input  logic signed [DW-1:0] x,
	input  logic signed [DW-1:0] y,
	input  logic [31:0]          z,
	input  logic [HW-1:0]        hgt,
	output cccu_pkg::ctl_t       ctl_s1,
	output logic signed [DW-1:0] x_s1,
	output logic signed [DW-1:0] y_s1,
	output logic [31:0]          z_s1,
	output logic [HW-1:0]        hgt_s1
);
	import cccu_pkg::*;

	localparam logic [31:0] TURN = atan_turn(5'(IDX));

	logic                 dir_neg;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	// A negative step direction turns the vector counterclockwise.
	assign dir_neg = ctl.kind ? y[DW-1] : ~z[31];
	assign dx      = y >>> IDX;
	assign dy      = x >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (dir_neg) begin
			x_s1 <= x - dx;
			y_s1 <= y + dy;
			z_s1 <= z - TURN;
		end else begin
			x_s1 <= x + dx;
			y_s1 <= y - dy;
			z_s1 <= z + TURN;
		end
		hgt_s1 <= hgt;
	end

endmodule

FILE: rtl/core/cylindrical_cartesian_converter_unit.sv
// Top level of the cylindrical / Cartesian coordinate converter, a fully pipelined CORDIC.
// Depends on cccu_pkg and instantiates one cccu_stage for every CORDIC row.
//
//   Channel  Handshake           Beat contents
//   -------  ------------------  --------------------------------------------------------
//   input    start, busy         kind, x_or_radius, y_value, angle_in, height
//   result   done (strobe only)  out_x_or_radius, out_y, out_angle, out_height
//
// A beat is taken at every rising edge where start is high; busy stays low because the
// pipeline never stops, so one beat per clock is sustained.
// Each beat passes through two stages for the gain multiply and pre-rotation, one per
// CORDIC row, and two for rounding, the radius gain multiply and saturation.
// Reset clears only the control words with their valid bits, so no stray done follows reset; beats in flight are lost.
// The receiver cannot hold results off, so done is a single-cycle strobe per beat.
module cylindrical_cartesian_converter_unit #(
	parameter int COORD_WIDTH   = cccu_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = cccu_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = cccu_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic signed [COORD_WIDTH-1:0] x_or_radius,
	input  logic signed [COORD_WIDTH-1:0] y_value,
	input  logic [ANGLE_WIDTH-1:0]        angle_in,
	input  logic signed [COORD_WIDTH-1:0] height,
	output logic                          done,
	output logic signed [COORD_WIDTH:0]   out_x_or_radius,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic [ANGLE_WIDTH-1:0]        out_angle,
	output logic signed [COORD_WIDTH-1:0] out_height
);
	import cccu_pkg::*;

	// Rows beyond the table length add nothing, so the count is capped there.
	localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	// Datapath width: sign, headroom for the sqrt(2) and CORDIC growth, and the fraction.
	localparam int DW   = COORD_WIDTH + FRAC_BITS + 3;
	// Width of radius times gain, a signed coordinate times a 33-bit signed constant.
	localparam int MW   = COORD_WIDTH + 33;
	// Bits dropped when the 32-bit internal angle is brought to the port width.
	localparam int SH   = 32 - ANGLE_WIDTH;
	// Unsigned magnitude of the final vector, at least 33 bits so a high part exists.
	localparam int UXW  = (DW - 1 > 33) ? DW - 1 : 33;
	localparam int LAT  = NSTG + 4;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ------------------------------------------------------------------------------------
	// Stage 1: gain multiply of the radius, quadrant fold of both kinds.
	// ------------------------------------------------------------------------------------
	logic [31:0]                 a_full;
	logic                        fold_rot;
	logic [31:0]                 z_rot;
	logic signed [COORD_WIDTH:0] vx_ext;
	logic signed [COORD_WIDTH:0] vy_ext;
	logic signed [MW-1:0]        gain_prod;

	// The angle is placed at the top of a 32-bit turn fraction.
	assign a_full = 32'(angle_in) << SH;
	// The second and third quarter turns are folded by half a turn, and the start vector
	// is negated to match, which keeps the residual within a quarter turn.
	assign fold_rot = a_full[31] ^ a_full[30];
	assign z_rot    = fold_rot ? {~a_full[31], a_full[30:0]} : a_full;
	assign vx_ext   = (COORD_WIDTH + 1)'(x_or_radius);
	assign vy_ext   = (COORD_WIDTH + 1)'(y_value);
	assign gain_prod = MW'(x_or_radius) * MW'($signed({1'b0, GAIN_Q32}));

	ctl_t                        ctl_s1;
	logic signed [MW-1:0]        prod_s1;
	logic signed [COORD_WIDTH:0] vx_s1;
	logic signed [COORD_WIDTH:0] vy_s1;
	logic [31:0]                 z_s1;
	logic                        fold_s1;
	logic [COORD_WIDTH-1:0]      hgt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld    <= accept;
			ctl_s1.kind   <= kind;
			ctl_s1.origin <= kind && (x_or_radius == '0) && (y_value == '0);
		end
	end

	// In the left half plane a vectoring beat is negated and starts at half a turn.
	always_ff @(posedge clk) begin
		prod_s1 <= gain_prod;
		fold_s1 <= fold_rot;
		hgt_s1  <= height;
		if (kind && x_or_radius[COORD_WIDTH-1]) begin
			vx_s1 <= -vx_ext;
			vy_s1 <= -vy_ext;
			z_s1  <= 32'h8000_0000;
		end else begin
			vx_s1 <= vx_ext;
			vy_s1 <= vy_ext;
			z_s1  <= kind ? 32'h0 : z_rot;
		end
	end

	// ------------------------------------------------------------------------------------
	// Stage 2: start vector in the fixed-point format of the CORDIC rows.
	// ------------------------------------------------------------------------------------
	logic signed [DW-1:0] mag_rot;
	logic signed [DW-1:0] x_init;
	logic signed [DW-1:0] y_init;

	// Floor of radius times gain in the row format; the fold negates after the floor.
	assign mag_rot = DW'(prod_s1 >>> (32 - FRAC_BITS));
	assign x_init  = ctl_s1.kind ? (DW'(vx_s1) <<< FRAC_BITS) :
	                 (fold_s1 ? -mag_rot : mag_rot);
	assign y_init  = ctl_s1.kind ? (DW'(vy_s1) <<< FRAC_BITS) : '0;

	ctl_t                   ctl_s2;
	logic signed [DW-1:0]   x_s2;
	logic signed [DW-1:0]   y_s2;
	logic [31:0]            z_s2;
	logic [COORD_WIDTH-1:0] hgt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s2   <= x_init;
		y_s2   <= y_init;
		z_s2   <= z_s1;
		hgt_s2 <= hgt_s1;
	end

	// ------------------------------------------------------------------------------------
	// CORDIC rows, one register stage each.
	// ------------------------------------------------------------------------------------
	ctl_t                   ctl_c [0:NSTG];
	logic signed [DW-1:0]   x_c   [0:NSTG];
	logic signed [DW-1:0]   y_c   [0:NSTG];
	logic [31:0]            z_c   [0:NSTG];
	logic [COORD_WIDTH-1:0] hgt_c [0:NSTG];

	assign ctl_c[0] = ctl_s2;
	assign x_c[0]   = x_s2;
	assign y_c[0]   = y_s2;
	assign z_c[0]   = z_s2;
	assign hgt_c[0] = hgt_s2;

	for (genvar gi = 0; gi < NSTG; gi++) begin : g_row
		cccu_stage #(
			.DW  (DW),
			.HW  (COORD_WIDTH),
			.IDX (gi)
		) u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl_c[gi]),
			.x      (x_c[gi]),
			.y      (y_c[gi]),
			.z      (z_c[gi]),
			.hgt    (hgt_c[gi]),
			.ctl_s1 (ctl_c[gi+1]),
			.x_s1   (x_c[gi+1]),
			.y_s1   (y_c[gi+1]),
			.z_s1   (z_c[gi+1]),
			.hgt_s1 (hgt_c[gi+1])
		);
	end

	// ------------------------------------------------------------------------------------
	// Stage 3 (after the rows): rounding and clamping of x and y, partial products of
	// the radius gain multiply, rounding of the angle.
	// ------------------------------------------------------------------------------------
	logic signed [DW-1:0] half_q;
	logic signed [DW-1:0] x_rnd;
	logic signed [DW-1:0] y_rnd;
	logic signed [DW-1:0] x_hi_lim;
	logic signed [DW-1:0] x_lo_lim;
	logic signed [DW-1:0] y_hi_lim;
	logic signed [DW-1:0] y_lo_lim;
	logic signed [DW-1:0] x_sat;
	logic signed [DW-1:0] y_sat;
	logic [UXW-1:0]       ux;
	logic [UXW-1:0]       hi_prod;
	logic [63:0]          lo_prod;
	logic [32:0]          ang_sum;

	assign half_q   = DW'(1) <<< (FRAC_BITS - 1);
	assign x_rnd    = (x_c[NSTG] + half_q) >>> FRAC_BITS;
	assign y_rnd    = (y_c[NSTG] + half_q) >>> FRAC_BITS;
	// x saturates one bit wider than y, so it keeps the full radius range.
	assign x_hi_lim = {{(DW - COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};
	assign x_lo_lim = ~x_hi_lim;
	assign y_hi_lim = {{(DW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	assign y_lo_lim = ~y_hi_lim;
	assign x_sat    = (x_rnd > x_hi_lim) ? x_hi_lim : ((x_rnd < x_lo_lim) ? x_lo_lim : x_rnd);
	assign y_sat    = (y_rnd > y_hi_lim) ? y_hi_lim : ((y_rnd < y_lo_lim) ? y_lo_lim : y_rnd);

	// A vectoring beat that ends marginally negative counts as zero length.
	assign ux      = x_c[NSTG][DW-1] ? '0 : UXW'(x_c[NSTG][DW-2:0]);
	// The magnitude times the gain is split at bit 32 so each product stays narrow;
	// the low product only contributes its upper half.
	assign hi_prod = UXW'(ux[UXW-1:32]) * UXW'(GAIN_Q32);
	assign lo_prod = 64'(ux[31:0]) * 64'(GAIN_Q32);
	// Round half up to the port width; a full turn wraps to zero.
	assign ang_sum = {z_c[NSTG], 1'b0} + (33'd1 << SH);

	ctl_t                          ctl_s3;
	logic signed [COORD_WIDTH:0]   rx_s3;
	logic signed [COORD_WIDTH-1:0] ry_s3;
	logic [UXW-1:0]                hi_s3;
	logic [31:0]                   lo_s3;
	logic [ANGLE_WIDTH-1:0]        ang_s3;
	logic [COORD_WIDTH-1:0]        hgt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_c[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		rx_s3  <= (COORD_WIDTH + 1)'(x_sat);
		ry_s3  <= COORD_WIDTH'(y_sat);
		hi_s3  <= hi_prod;
		lo_s3  <= lo_prod[63:32];
		ang_s3 <= ang_sum[32:SH+1];
		hgt_s3 <= hgt_c[NSTG];
	end

	// ------------------------------------------------------------------------------------
	// Stage 4: radius sum, rounding and saturation, and the result registers.
	// ------------------------------------------------------------------------------------
	logic [UXW:0]             rad_prod;
	logic [UXW+1:0]           rad_sum;
	logic [UXW+1:0]           rad_q;
	logic [COORD_WIDTH-1:0]   rad_sat;

	assign rad_prod = (UXW + 1)'(hi_s3) + (UXW + 1)'(lo_s3);
	assign rad_sum  = (UXW + 2)'(rad_prod) + ((UXW + 2)'(1) << (FRAC_BITS - 1));
	assign rad_q    = rad_sum >> FRAC_BITS;
	assign rad_sat  = (rad_q > (UXW + 2)'({COORD_WIDTH{1'b1}})) ? '1 : COORD_WIDTH'(rad_q);

	logic                          vld_s4;
	logic signed [COORD_WIDTH:0]   xr_s4;
	logic signed [COORD_WIDTH-1:0] y_s4;
	logic [ANGLE_WIDTH-1:0]        ang_s4;
	logic [COORD_WIDTH-1:0]        hgt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= ctl_s3.vld;
		end
	end

	// Each kind zeroes the field it does not produce; the origin gives radius and angle 0.
	always_ff @(posedge clk) begin
		if (ctl_s3.kind) begin
			xr_s4  <= ctl_s3.origin ? '0 : {1'b0, rad_sat};
			y_s4   <= '0;
			ang_s4 <= ctl_s3.origin ? '0 : ang_s3;
		end else begin
			xr_s4  <= rx_s3;
			y_s4   <= ry_s3;
			ang_s4 <= '0;
		end
		hgt_s4 <= hgt_s3;
	end

	assign done            = vld_s4;
	assign out_x_or_radius = xr_s4;
	assign out_y           = y_s4;
	assign out_angle       = ang_s4;
	assign out_height      = hgt_s4;

	// ------------------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------------------
	a_beat_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted beat did not produce a result at the pipeline latency");

	a_done_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result strobe without a matching accepted beat");

	a_height_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_height == $past(height, LAT))
		else $error("height lost its alignment with the result beat");

	a_vector_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind |-> ##LAT (!out_x_or_radius[COORD_WIDTH] && out_y == '0))
		else $error("vectoring result has a negative radius or a nonzero y");

	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind && x_or_radius == '0 && y_value == '0 |->
		##LAT (out_x_or_radius == '0 && out_angle == '0))
		else $error("origin did not give zero radius and zero angle");

endmodule

FILE: dv/cylindrical_cartesian_converter_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cylindrical_cartesian_converter_unit: directed table, then random beats.
// Depends on cccu_pkg for sizes, the fraction width and the gain constant; reads no files.
module cylindrical_cartesian_converter_unit_tb;

	// The block runs at its default sizes; the predictor below is written for them.
	localparam int CW      = cccu_pkg::COORD_WIDTH_DEF;
	localparam int AW      = cccu_pkg::ANGLE_WIDTH_DEF;
	localparam int NSTAGES = cccu_pkg::CORDIC_STAGES_DEF;
	localparam int FRAC    = cccu_pkg::FRAC_BITS;

	// Conversion direction carried by the kind input.
	localparam logic TO_CART = 1'b0;
	localparam logic TO_CYL  = 1'b1;

	// Directed rows either carry a hand-written answer or go through the predictor.
	localparam bit PINNED    = 1'b1;
	localparam bit PREDICTED = 1'b0;

	localparam int  RANDOM_BEATS = 1780;
	localparam int  CALM_TAIL    = 300;   // final random beats sent back to back
	localparam int  HALF_CYCLE   = 6;

	localparam longint      GAIN     = {32'd0, cccu_pkg::GAIN_Q32};
	localparam logic [63:0] GAIN_U   = {32'd0, cccu_pkg::GAIN_Q32};
	localparam longint      XR_MAX   = (longint'(1) << CW) - 1;
	localparam longint      Y_MAX    = (longint'(1) << (CW - 1)) - 1;
	localparam longint      HALF_LSB = longint'(1) << (FRAC - 1);

	// Arctangent of 2^-i as a 32-bit fraction of a full turn, rounded to nearest.
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct {
		logic          k;
		logic [CW-1:0] xr;
		logic [CW-1:0] yv;
		logic [AW-1:0] ang;
		logic [CW-1:0] hgt;
	} coord_beat_t;

	typedef struct {
		logic [CW:0]   xr;
		logic [CW-1:0] y;
		logic [AW-1:0] ang;
		logic [CW-1:0] hgt;
	} coord_result_t;

	typedef struct {
		coord_beat_t   b;
		bit            pinned;
		coord_result_t gold;
	} table_row_t;

	// Block ports. Every input holds a known value from time zero.
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 kind        = TO_CART;
	logic signed [CW-1:0] x_or_radius = '0;
	logic signed [CW-1:0] y_value     = '0;
	logic [AW-1:0]        angle_in    = '0;
	logic signed [CW-1:0] height      = '0;
	logic                 busy;
	logic                 done;
	logic signed [CW:0]   out_x_or_radius;
	logic signed [CW-1:0] out_y;
	logic [AW-1:0]        out_angle;
	logic signed [CW-1:0] out_height;

	// Sideband that travels with the beat on the input ports, so the monitor knows
	// whether the beat it sees accepted has a hand-written answer.
	bit            beat_pinned = 1'b0;
	coord_result_t beat_gold   = '{default: '0};

	coord_result_t due_conversions [$];   // answers still owed by the pipeline, oldest first
	table_row_t    directed_rows [$];

	int mismatch_count = 0;
	int checked_count  = 0;
	int cart_beats     = 0;
	int cyl_beats      = 0;

	cylindrical_cartesian_converter_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.x_or_radius     (x_or_radius),
		.y_value         (y_value),
		.angle_in        (angle_in),
		.height          (height),
		.done            (done),
		.out_x_or_radius (out_x_or_radius),
		.out_y           (out_y),
		.out_angle       (out_angle),
		.out_height      (out_height)
	);

	always begin
		#HALF_CYCLE clk = 1'b1;
		#HALF_CYCLE clk = 1'b0;
	end

	// Bit-exact model of one conversion. Both directions keep the coordinates in a
	// 64-bit signed value with FRAC fraction bits; the angle is a 32-bit turn fraction.
	// Arithmetic right shifts of longint are floors, which is what the rows need.
	function automatic coord_result_t cordic_convert(input coord_beat_t b);
		longint        x;
		longint        y;
		longint        z;
		longint        dx;
		longint        dy;
		logic [31:0]   turn;
		logic [63:0]   mag;
		logic [63:0]   prod;
		logic [63:0]   rad;
		logic [63:0]   ang;
		coord_result_t res;
		res     = '{default: '0};
		res.hgt = b.hgt;
		if (b.k == TO_CART) begin
			// Rotation mode: start from (r*K, 0) and turn it by the input angle.
			x    = (longint'($signed(b.xr)) * GAIN) >>> (32 - FRAC);
			y    = 0;
			turn = {b.ang, {(32 - AW){1'b0}}};
			// Angles in the second and third quarter: flip the vector and take a half
			// turn off, so the rows only have to cover the residual quarter turn.
			if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
				x    = -x;
				turn = turn - 32'h8000_0000;
			end
			z = longint'($signed(turn));
			for (int i = 0; i < NSTAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(ATAN_TURNS[i]);
				end else begin
					x += dx;
					y -= dy;
					z += longint'(ATAN_TURNS[i]);
				end
			end
			x = (x + HALF_LSB) >>> FRAC;
			y = (y + HALF_LSB) >>> FRAC;
			if (x > XR_MAX)
				x = XR_MAX;
			else if (x < -XR_MAX - 1)
				x = -XR_MAX - 1;
			if (y > Y_MAX)
				y = Y_MAX;
			else if (y < -Y_MAX - 1)
				y = -Y_MAX - 1;
			res.xr = (CW + 1)'(x);
			res.y  = CW'(y);
		end else begin
			// The origin has no direction: radius and angle are both zero.
			if (b.xr == '0 && b.yv == '0)
				return res;
			x    = longint'($signed(b.xr)) <<< FRAC;
			y    = longint'($signed(b.yv)) <<< FRAC;
			turn = '0;
			// Left half plane: mirror through the origin and start at a half turn.
			if (x < 0) begin
				x    = -x;
				y    = -y;
				turn = 32'h8000_0000;
			end
			for (int i = 0; i < NSTAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y < 0) begin
					x    -= dx;
					y    += dy;
					turn -= ATAN_TURNS[i];
				end else begin
					x    += dx;
					y    -= dy;
					turn += ATAN_TURNS[i];
				end
			end
			mag  = (x < 0) ? 64'd0 : 64'(x);
			prod = (mag >> 32) * GAIN_U + (((mag & 64'hFFFF_FFFF) * GAIN_U) >> 32);
			rad  = (prod + (64'd1 << (FRAC - 1))) >> FRAC;
			if (rad > 64'(XR_MAX))
				rad = 64'(XR_MAX);
			// A turn that rounds up to a full one wraps to zero through the truncation.
			ang    = ({32'd0, turn} + (64'd1 << (32 - AW - 1))) >> (32 - AW);
			res.xr = (CW + 1)'(rad);
			res.ang = AW'(ang);
		end
		return res;
	endfunction

	// Monitor: the result ports are compared at the edge that closes the strobe
	// cycle, and every beat the block takes gets its answer queued at its edge.
	always @(posedge clk) begin : monitor
		coord_result_t seen;
		coord_result_t want;
		coord_beat_t   taken;
		if (arst_n) begin
			if (done) begin
				seen = '{out_x_or_radius, out_y, out_angle, out_height};
				if (due_conversions.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Result strobe with no beat outstanding: xr=%0d y=%0d angle=%0d h=%0d",
							$signed(seen.xr), $signed(seen.y), seen.ang, $signed(seen.hgt));
				end else begin
					want = due_conversions.pop_front();
					checked_count++;
					if (seen.xr !== want.xr || seen.y !== want.y ||
							seen.ang !== want.ang || seen.hgt !== want.hgt) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("Result %0d differs: want xr=%0d y=%0d angle=%0d h=%0d, got xr=%0d y=%0d angle=%0d h=%0d",
								checked_count, $signed(want.xr), $signed(want.y), want.ang,
								$signed(want.hgt), $signed(seen.xr), $signed(seen.y), seen.ang,
								$signed(seen.hgt));
					end
				end
			end
			if (start && !busy) begin
				taken = '{kind, x_or_radius, y_value, angle_in, height};
				if (kind == TO_CART)
					cart_beats++;
				else
					cyl_beats++;
				due_conversions.push_back(beat_pinned ? beat_gold : cordic_convert(taken));
			end
		end
	end

	// Put a beat on the ports at the current edge and return at the edge that takes it.
	// The caller either drives the next beat at that edge or drops start.
	task automatic issue(input coord_beat_t b, input bit pinned, input coord_result_t gold);
		start       <= 1'b1;
		kind        <= b.k;
		x_or_radius <= b.xr;
		y_value     <= b.yv;
		angle_in    <= b.ang;
		height      <= b.hgt;
		beat_pinned <= pinned;
		beat_gold   <= gold;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Leave the input idle for a number of cycles, with junk on the data ports.
	task automatic hold_off(input int cycles);
		start       <= 1'b0;
		kind        <= 1'($urandom);
		x_or_radius <= CW'($urandom);
		y_value     <= CW'($urandom);
		angle_in    <= AW'($urandom);
		height      <= CW'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until the pipeline has delivered every answer it owes.
	task automatic drain();
		hold_off(1);
		while (due_conversions.size() != 0)
			@(posedge clk);
	endtask

	task automatic row(input bit pin, input logic k, input logic [CW-1:0] xr,
			input logic [CW-1:0] yv, input logic [AW-1:0] ang, input logic [CW-1:0] hgt,
			input logic [CW:0] gx, input logic [CW-1:0] gy, input logic [AW-1:0] ga,
			input logic [CW-1:0] gh);
		directed_rows.push_back('{'{k, xr, yv, ang, hgt}, pin, '{gx, gy, ga, gh}});
	endtask

	// Coordinates lean toward the extremes and toward small values, where the
	// rounding and sign handling are most exposed; the rest are uniform.
	function automatic logic [CW-1:0] random_coord();
		logic [CW-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0:       v = {1'b1, {(CW - 1){1'b0}}};
					1:       v = {1'b0, {(CW - 1){1'b1}}};
					2:       v = '0;
					3:       v = '1;
					default: v = CW'(1);
				endcase
			end
			1, 2:    v = CW'($urandom_range(0, 128)) - CW'(64);
			default: v = CW'($urandom);
		endcase
		return v;
	endfunction

	function automatic coord_beat_t random_beat();
		coord_beat_t b;
		b.k   = 1'($urandom);
		b.xr  = random_coord();
		b.yv  = random_coord();
		b.hgt = CW'($urandom);
		// A quarter of the angles sit within a few units of a quadrant boundary.
		if ($urandom_range(0, 3) == 0)
			b.ang = (AW'($urandom_range(0, 3)) << (AW - 2)) + AW'($urandom_range(0, 6)) - AW'(3);
		else
			b.ang = AW'($urandom);
		if (b.k == TO_CYL && $urandom_range(0, 39) == 0) begin
			b.xr = '0;
			b.yv = '0;
		end
		return b;
	endfunction

	initial begin : stimulus
		int gap_odds;
		// Origin in the vectoring direction: zero radius and angle, height copied.
		row(PINNED,    TO_CYL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0, 16'h0000);
		row(PINNED,    TO_CYL,  16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF, '0, '0, '0, 16'h7FFF);
		row(PINNED,    TO_CYL,  16'h0000, 16'h0000, 16'h8000, 16'h8000, '0, '0, '0, 16'h8000);
		// Zero radius rotated anywhere stays at the origin; y_value is ignored here.
		row(PINNED,    TO_CART, 16'h0000, 16'h8000, 16'h4000, 16'hFFFF, '0, '0, '0, 16'hFFFF);
		row(PINNED,    TO_CART, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0001, '0, '0, '0, 16'h0001);
		// Largest radius on every quadrant boundary and next to two of them.
		row(PREDICTED, TO_CART, 16'h7FFF, 16'h0000, 16'h0000, 16'h1234, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'h7FFF, 16'h0000, 16'h3FFF, 16'h0000, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'h7FFF, 16'h0000, 16'h4000, 16'h8000, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'h7FFF, 16'h0000, 16'hBFFF, 16'h5555, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'h7FFF, 16'h0000, 16'hC000, 16'hAAAA, '0, '0, '0, '0);
		// Most negative radius without the pre-rotation, then small radii with and without it.
		row(PREDICTED, TO_CART, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'h8000, 16'h0000, 16'h2000, 16'hFFFF, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'h0001, 16'h0000, 16'h6000, 16'h0001, '0, '0, '0, '0);
		row(PREDICTED, TO_CART, 16'hFFFF, 16'h7FFF, 16'hE000, 16'h8000, '0, '0, '0, '0);
		// Vectoring at the corners, on the axes and in the left half plane.
		row(PREDICTED, TO_CYL,  16'h7FFF, 16'h7FFF, 16'h0000, 16'h7FFF, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'h8000, 16'h8000, 16'hFFFF, 16'h8000, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'h8000, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'h0000, 16'h8000, 16'h0000, 16'h0001, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'hFFFF, 16'h0001, 16'h0000, 16'h0000, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'h0001, 16'hFFFF, 16'h0000, 16'h0000, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'h8000, 16'h7FFF, 16'hAAAA, 16'h0000, '0, '0, '0, '0);
		row(PREDICTED, TO_CYL,  16'h7FFF, 16'h8000, 16'hFFFF, 16'h5A5A, '0, '0, '0, '0);

		// Reset is held and then released at a rising edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if ($urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 16));
			issue(directed_rows[i].b, directed_rows[i].pinned, directed_rows[i].gold);
		end

		// Random part. The idle rate changes every 64 beats, from none to heavy,
		// so gaps land on every stage of the pipeline; the tail runs flat out.
		gap_odds = 0;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 64 == 0)
				gap_odds = $urandom_range(0, 3);
			if (n == RANDOM_BEATS / 3)
				drain();
			else if (n < RANDOM_BEATS - CALM_TAIL && gap_odds != 0 &&
					$urandom_range(0, 4 * gap_odds - 1) == 0)
				hold_off($urandom_range(1, 16));
			issue(random_beat(), PREDICTED, '{default: '0});
		end

		// Wait for the last answers, then a little past the pipeline depth so a
		// stray strobe would still be caught.
		drain();
		repeat (NSTAGES + 8) @(posedge clk);

		$display("Sent %0d beats toward Cartesian and %0d toward cylindrical.",
			cart_beats, cyl_beats);
		$display("Compared %0d results, %0d of them wrong.", checked_count, mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Guard against a hung handshake or missing results.
	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding.", due_conversions.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
